@@ rtl/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg
// Shared constants, types and codes of the shortest common supersequence unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scs_pkg;

  localparam int MAX_LEN = 32;
  localparam int SYM_W   = 8;
  localparam int MODE_W  = 2;
  localparam int TAG_W   = 2;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int VAL_W   = $clog2(MAX_LEN + 1);
  localparam int CNT_W   = $clog2(2 * MAX_LEN + 1);
  localparam int BUF_AW  = $clog2(2 * MAX_LEN);

  localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  localparam logic [TAG_W-1:0] TAG_COMMON = 2'd0;
  localparam logic [TAG_W-1:0] TAG_FIRST  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_SECOND = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_TRACE,
    S_READ,
    S_SHOW
  } state_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] row;
    logic [SYM_W-1:0] sym;
    logic [VAL_W-1:0] val;
  } link_t;

  typedef struct packed {
    logic             clear;
    logic             load_en;
    logic [IDX_W-1:0] load_idx;
    logic [SYM_W-1:0] load_sym;
    logic [IDX_W-1:0] rd_row;
  } cell_ctrl_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SYM_W-1:0] sym;
  } buf_entry_t;

endpackage

`default_nettype wire

@@ rtl/scs_in_if.sv @@
// ----------------------------------------------------------------------------
// scs_in_if
// Input channel: mode and symbol with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface scs_in_if;
  logic                             valid;
  logic                             ready;
  logic [scs_pkg::MODE_W-1:0]       mode;
  logic [scs_pkg::SYM_W-1:0]        symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink   (input valid, input mode, input symbol, output ready);
endinterface

`default_nettype wire

@@ rtl/scs_out_if.sv @@
// ----------------------------------------------------------------------------
// scs_out_if
// Result channel: supersequence symbol, origin tag and last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface scs_out_if;
  logic                             valid;
  logic                             ready;
  logic [scs_pkg::SYM_W-1:0]        out_symbol;
  logic [scs_pkg::TAG_W-1:0]        origin_tag;
  logic                             last;

  modport source (output valid, output out_symbol, output origin_tag, output last,
                  input ready);
  modport sink   (input valid, input out_symbol, input origin_tag, input last,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/scs_cell.sv @@
// ----------------------------------------------------------------------------
// scs_cell
// One column of the LCS wavefront: holds a second-string symbol, computes
// its table cell per row and keeps the up-greater-than-left decision bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scs_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [scs_pkg::IDX_W-1:0]   col_idx,
  input  wire scs_pkg::cell_ctrl_t         ctrl,
  input  wire scs_pkg::link_t              link_in,
  output scs_pkg::link_t                   link_out,
  output logic [scs_pkg::SYM_W-1:0]        b_sym,
  output logic                             dir_bit
);

  scs_pkg::link_t                  link_r;
  logic [scs_pkg::SYM_W-1:0]       b_r;
  logic [scs_pkg::VAL_W-1:0]       up_r;
  logic [scs_pkg::VAL_W-1:0]       dg_r;
  logic [scs_pkg::MAX_LEN-1:0]     dir_r;
  logic [scs_pkg::VAL_W-1:0]       val_nxt;
  logic                            up_gt;

  always_comb begin
    up_gt = (up_r > link_in.val);
    if (link_in.sym == b_r) begin
      val_nxt = dg_r + scs_pkg::VAL_W'(1);
    end else begin
      val_nxt = up_gt ? up_r : link_in.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.vld <= 1'b0;
    end else if (ctrl.clear) begin
      link_r.vld <= 1'b0;
    end else begin
      link_r.vld <= link_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.vld) begin
      link_r.row <= link_in.row;
      link_r.sym <= link_in.sym;
      link_r.val <= val_nxt;
      dir_r[link_in.row] <= up_gt;
    end
    if (ctrl.clear) begin
      up_r <= '0;
      dg_r <= '0;
    end else if (link_in.vld) begin
      up_r <= val_nxt;
      dg_r <= link_in.val;
    end
    if (ctrl.load_en && ctrl.load_idx == col_idx) begin
      b_r <= ctrl.load_sym;
    end
  end

  assign link_out = link_r;
  assign b_sym    = b_r;
  assign dir_bit  = dir_r[ctrl.rd_row];

endmodule

`default_nettype wire

@@ rtl/scs_rev_buf.sv @@
// ----------------------------------------------------------------------------
// scs_rev_buf
// Traceback buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scs_rev_buf (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [scs_pkg::BUF_AW-1:0]   waddr,
  input  wire scs_pkg::buf_entry_t          wdata,
  input  wire logic                         re,
  input  wire logic [scs_pkg::BUF_AW-1:0]   raddr,
  output scs_pkg::buf_entry_t               rdata
);

  scs_pkg::buf_entry_t mem [0:2*scs_pkg::MAX_LEN-1];
  scs_pkg::buf_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/shortest_common_supersequence_unit.sv @@
// ----------------------------------------------------------------------------
// shortest_common_supersequence_unit
// Loads two byte strings and emits their shortest common supersequence.
// ----------------------------------------------------------------------------
// A compute item sweeps the LCS table through the row of 32 column cells
// (one row enters per cycle and moves one cell a cycle), then traces back
// one supersequence symbol per step into the traceback buffer, and then
// passes each result item through the registered read of the traceback
// buffer, waiting while the receiver holds off. No item is taken after the
// compute item until its last result is delivered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shortest_common_supersequence_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  scs_in_if.sink      in_ch,
  scs_out_if.source   out_ch
);

  localparam int N = scs_pkg::MAX_LEN;

  scs_pkg::state_t                 state_r, state_nxt;
  logic [scs_pkg::LEN_W-1:0]       a_len_r, b_len_r;
  logic [scs_pkg::SYM_W-1:0]       a_str_r [0:N-1];
  logic [scs_pkg::LEN_W:0]         feed_cnt_r;
  logic [scs_pkg::LEN_W-1:0]       i_r, j_r;
  logic [scs_pkg::CNT_W-1:0]       k_r;
  logic [scs_pkg::BUF_AW-1:0]      p_r;

  scs_pkg::cell_ctrl_t             ctrl;
  scs_pkg::link_t                  links [0:N];
  logic [scs_pkg::SYM_W-1:0]       b_syms [0:N-1];
  logic [N-1:0]                    dirs;

  logic                            in_acc, out_acc;
  logic [scs_pkg::IDX_W-1:0]       a_addr, i_m1, j_m1;
  logic [scs_pkg::SYM_W-1:0]       a_sym, b_sym;
  logic                            fill_done, feeding;
  logic                            buf_we, buf_re, clear_len;
  scs_pkg::buf_entry_t             buf_wdata, buf_rdata;
  logic [scs_pkg::TAG_W-1:0]       tr_tag;
  logic                            tr_dec_i, tr_dec_j;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  assign i_m1   = scs_pkg::IDX_W'(i_r - scs_pkg::LEN_W'(1));
  assign j_m1   = scs_pkg::IDX_W'(j_r - scs_pkg::LEN_W'(1));
  assign a_addr = (state_r == scs_pkg::S_FILL) ? feed_cnt_r[scs_pkg::IDX_W-1:0] : i_m1;
  assign a_sym  = a_str_r[a_addr];
  assign b_sym  = b_syms[j_m1];

  assign feeding   = (state_r == scs_pkg::S_FILL) && (feed_cnt_r < {1'b0, a_len_r});
  assign fill_done = (feed_cnt_r == ({1'b0, a_len_r} + (scs_pkg::LEN_W+1)'(N - 1)));

  // wavefront feed into the first cell
  assign links[0] = {feeding, feed_cnt_r[scs_pkg::IDX_W-1:0], a_sym, scs_pkg::VAL_W'(0)};

  always_comb begin
    ctrl.clear    = in_acc && (in_ch.mode == scs_pkg::MODE_COMPUTE);
    ctrl.load_en  = in_acc && (in_ch.mode == scs_pkg::MODE_LOAD_B) &&
                    (b_len_r < scs_pkg::LEN_W'(N));
    ctrl.load_idx = b_len_r[scs_pkg::IDX_W-1:0];
    ctrl.load_sym = in_ch.symbol;
    ctrl.rd_row   = i_m1;
  end

  for (genvar c = 0; c < N; c++) begin : g_cell
    scs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .col_idx  (scs_pkg::IDX_W'(c)),
      .ctrl     (ctrl),
      .link_in  (links[c]),
      .link_out (links[c+1]),
      .b_sym    (b_syms[c]),
      .dir_bit  (dirs[c])
    );
  end

  // traceback decision
  always_comb begin
    tr_tag   = scs_pkg::TAG_SECOND;
    tr_dec_i = 1'b0;
    tr_dec_j = 1'b0;
    priority if (i_r != '0 && j_r != '0 && a_sym == b_sym) begin
      tr_tag   = scs_pkg::TAG_COMMON;
      tr_dec_i = 1'b1;
      tr_dec_j = 1'b1;
    end else if (i_r != '0 && (j_r == '0 || dirs[j_m1])) begin
      tr_tag   = scs_pkg::TAG_FIRST;
      tr_dec_i = 1'b1;
    end else if (j_r != '0) begin
      tr_tag   = scs_pkg::TAG_SECOND;
      tr_dec_j = 1'b1;
    end
  end

  assign buf_wdata.tag = tr_tag;
  assign buf_wdata.sym = (tr_tag == scs_pkg::TAG_SECOND) ? b_sym : a_sym;

  scs_rev_buf u_rev_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (k_r[scs_pkg::BUF_AW-1:0]),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (p_r),
    .rdata (buf_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scs_pkg::S_IDLE: begin
        if (in_acc && in_ch.mode == scs_pkg::MODE_COMPUTE) begin
          state_nxt = scs_pkg::S_FILL;
        end
      end
      scs_pkg::S_FILL: begin
        if (fill_done) begin
          state_nxt = scs_pkg::S_TRACE;
        end
      end
      scs_pkg::S_TRACE: begin
        if (i_r == '0 && j_r == '0) begin
          state_nxt = (k_r == '0) ? scs_pkg::S_IDLE : scs_pkg::S_READ;
        end
      end
      scs_pkg::S_READ: state_nxt = scs_pkg::S_SHOW;
      scs_pkg::S_SHOW: begin
        if (out_acc) begin
          state_nxt = (p_r == '0) ? scs_pkg::S_IDLE : scs_pkg::S_READ;
        end
      end
      default: state_nxt = scs_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready  = (state_r == scs_pkg::S_IDLE);
    out_ch.valid = (state_r == scs_pkg::S_SHOW);
    buf_re       = (state_r == scs_pkg::S_READ);
    buf_we       = (state_r == scs_pkg::S_TRACE) && (i_r != '0 || j_r != '0);
    clear_len    = ((state_r == scs_pkg::S_TRACE) && i_r == '0 && j_r == '0 && k_r == '0) ||
                   ((state_r == scs_pkg::S_SHOW) && out_acc && p_r == '0);
  end

  assign out_ch.out_symbol = buf_rdata.sym;
  assign out_ch.origin_tag = buf_rdata.tag;
  assign out_ch.last       = (p_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scs_pkg::S_IDLE;
      a_len_r <= '0;
      b_len_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clear_len) begin
        a_len_r <= '0;
        b_len_r <= '0;
      end else if (in_acc && in_ch.mode == scs_pkg::MODE_LOAD_A &&
                   a_len_r < scs_pkg::LEN_W'(N)) begin
        a_len_r <= a_len_r + scs_pkg::LEN_W'(1);
      end else if (ctrl.load_en) begin
        b_len_r <= b_len_r + scs_pkg::LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.mode == scs_pkg::MODE_LOAD_A && a_len_r < scs_pkg::LEN_W'(N)) begin
      a_str_r[a_len_r[scs_pkg::IDX_W-1:0]] <= in_ch.symbol;
    end
    if (ctrl.clear) begin
      feed_cnt_r <= '0;
      i_r        <= a_len_r;
      j_r        <= b_len_r;
      k_r        <= '0;
    end else if (state_r == scs_pkg::S_FILL) begin
      feed_cnt_r <= feed_cnt_r + (scs_pkg::LEN_W+1)'(1);
    end else if (buf_we) begin
      k_r <= k_r + scs_pkg::CNT_W'(1);
      if (tr_dec_i) begin
        i_r <= i_r - scs_pkg::LEN_W'(1);
      end
      if (tr_dec_j) begin
        j_r <= j_r - scs_pkg::LEN_W'(1);
      end
    end
    if (state_r == scs_pkg::S_TRACE && state_nxt == scs_pkg::S_READ) begin
      p_r <= scs_pkg::BUF_AW'(k_r - scs_pkg::CNT_W'(1));
    end else if (state_r == scs_pkg::S_SHOW && out_acc && p_r != '0) begin
      p_r <= p_r - scs_pkg::BUF_AW'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while a result is pending");

  a_len_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last) |=> (a_len_r == '0 && b_len_r == '0))
    else $error("lengths not cleared after final item");

  a_trace_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scs_pkg::S_TRACE) |->
      (scs_pkg::CNT_W'(k_r) + scs_pkg::CNT_W'(i_r) + scs_pkg::CNT_W'(j_r) <=
       scs_pkg::CNT_W'(a_len_r) + scs_pkg::CNT_W'(b_len_r)))
    else $error("traceback count out of step with indices");
`endif

endmodule

`default_nettype wire

@@ sim/scs_test_if.sv @@
// ----------------------------------------------------------------------------
// scs_test_if
// Bench copies of the channels are the RTL interfaces; this file adds only the expected-symbol record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scs_test_pkg;

  typedef struct packed {
    logic [scs_pkg::SYM_W-1:0] symbol;
    logic [scs_pkg::TAG_W-1:0] tag;
    logic                      last;
  } super_sym_t;
endpackage

@@ sim/shortest_common_supersequence_unit_test.sv @@
// ----------------------------------------------------------------------------
// shortest_common_supersequence_unit_test
// Loads fixed edge cases and random string pairs, predicts each supersequence from an LCS table
// kept in the bench, and checks every emitted symbol, tag and last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shortest_common_supersequence_unit_test;

  localparam int LIMIT = 2000000;
  localparam logic [scs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic failed;
  logic hold_off;
  logic long_hold_req;
  int   cycles;

  scs_in_if  in_ch();
  scs_out_if out_ch();

  shortest_common_supersequence_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  logic [scs_pkg::SYM_W-1:0]  str_a [scs_pkg::MAX_LEN];
  logic [scs_pkg::SYM_W-1:0]  str_b [scs_pkg::MAX_LEN];
  int                         len_a;
  int                         len_b;
  scs_test_pkg::super_sym_t   pending_syms [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("shortest_common_supersequence_unit_test failed");
      $finish;
    end
  end

  function automatic void predict_supersequence();
    int                       lcs [scs_pkg::MAX_LEN+1][scs_pkg::MAX_LEN+1];
    scs_test_pkg::super_sym_t rev [$];
    scs_test_pkg::super_sym_t s;
    int                       i;
    int                       j;
    for (i = 0; i <= len_a; i++)
      for (j = 0; j <= len_b; j++) begin
        if (i == 0 || j == 0) lcs[i][j] = 0;
        else if (str_a[i-1] == str_b[j-1]) lcs[i][j] = lcs[i-1][j-1] + 1;
        else lcs[i][j] = (lcs[i-1][j] > lcs[i][j-1]) ? lcs[i-1][j] : lcs[i][j-1];
      end
    i = len_a;
    j = len_b;
    while (i > 0 || j > 0) begin
      s.last = 1'b0;
      if (i > 0 && j > 0 && str_a[i-1] == str_b[j-1]) begin
        s.symbol = str_a[i-1]; s.tag = scs_pkg::TAG_COMMON; i--; j--;
      end else if (i > 0 && (j == 0 || lcs[i-1][j] > lcs[i][j-1])) begin
        s.symbol = str_a[i-1]; s.tag = scs_pkg::TAG_FIRST; i--;
      end else begin
        s.symbol = str_b[j-1]; s.tag = scs_pkg::TAG_SECOND; j--;
      end
      rev.push_back(s);
    end
    for (i = rev.size() - 1; i >= 0; i--) begin
      s = rev[i];
      s.last = (i == 0);
      pending_syms.push_back(s);
    end
    len_a = 0;
    len_b = 0;
  endfunction

  task automatic send_item(input logic [scs_pkg::MODE_W-1:0] mode,
                           input logic [scs_pkg::SYM_W-1:0] sym,
                           input bit gaps = 1);
    int gap;
    gap = 0;
    if (gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.symbol <= sym;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (mode)
      scs_pkg::MODE_LOAD_A:
        if (len_a < scs_pkg::MAX_LEN) begin str_a[len_a] = sym; len_a++; end
      scs_pkg::MODE_LOAD_B:
        if (len_b < scs_pkg::MAX_LEN) begin str_b[len_b] = sym; len_b++; end
      scs_pkg::MODE_COMPUTE: predict_supersequence();
      default: ;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_syms.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_pair(input int na, input int nb, input int alpha);
    int k;
    for (k = 0; k < na; k++)
      send_item(scs_pkg::MODE_LOAD_A, 8'($urandom_range(0, alpha - 1)));
    for (k = 0; k < nb; k++)
      send_item(scs_pkg::MODE_LOAD_B, 8'($urandom_range(0, alpha - 1)));
    send_item(scs_pkg::MODE_COMPUTE, 8'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_syms.size() == 0) begin
        $display("%0t: unexpected symbol %h tag %0d last %b", $time,
                 out_ch.out_symbol, out_ch.origin_tag, out_ch.last);
        failed <= 1'b1;
      end else begin
        if (out_ch.out_symbol !== pending_syms[0].symbol ||
            out_ch.origin_tag !== pending_syms[0].tag ||
            out_ch.last !== pending_syms[0].last) begin
          $display("%0t: expected sym %h tag %0d last %b, got sym %h tag %0d last %b",
                   $time, pending_syms[0].symbol, pending_syms[0].tag,
                   pending_syms[0].last, out_ch.out_symbol, out_ch.origin_tag,
                   out_ch.last);
          failed <= 1'b1;
        end
        void'(pending_syms.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold_req && !hold_off) begin
      hold_off <= 1'b1;
      out_ch.ready <= 1'b0;
      stall = 400;
      while (stall > 0) begin
        @(posedge clk);
        stall--;
      end
      hold_off <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ch.ready <= 1'b0;
      stall = ($urandom_range(0, 12) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      repeat (stall) @(posedge clk);
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic test_edges();
    send_item(scs_pkg::MODE_COMPUTE, 8'h00);
    send_item(scs_pkg::MODE_LOAD_A, 8'h00);
    send_item(scs_pkg::MODE_COMPUTE, 8'hFF);
    send_item(scs_pkg::MODE_LOAD_B, 8'hFF);
    send_item(scs_pkg::MODE_COMPUTE, 8'h00);
    send_item(scs_pkg::MODE_LOAD_A, 8'hAA);
    send_item(scs_pkg::MODE_LOAD_B, 8'hAA);
    send_item(scs_pkg::MODE_COMPUTE, 8'h55);
    send_item(MODE_UNUSED, 8'h55);
    send_item(scs_pkg::MODE_LOAD_A, 8'h55);
    send_item(MODE_UNUSED, 8'hFF);
    send_item(scs_pkg::MODE_LOAD_B, 8'h0F);
    send_item(scs_pkg::MODE_COMPUTE, 8'h00);
    drain();
  endtask

  task automatic test_full_strings();
    send_pair(scs_pkg::MAX_LEN + 2, scs_pkg::MAX_LEN + 1, 4);
    drain();
  endtask

  task automatic test_backpressure();
    long_hold_req <= 1'b1;
    wait (hold_off);
    long_hold_req <= 1'b0;
    send_pair(3, 2, 3);
    send_pair(2, 3, 2);
    drain();
  endtask

  task automatic test_random();
    int n;
    for (n = 0; n < 6; n++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(MODE_UNUSED, 8'($urandom));
      send_pair($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(1, 256));
      if (n == 3) drain();
    end
    drain();
  endtask

  initial begin
    failed        = 1'b0;
    hold_off      = 1'b0;
    long_hold_req = 1'b0;
    cycles        = 0;
    len_a         = 0;
    len_b         = 0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = scs_pkg::MODE_LOAD_A;
    in_ch.symbol  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_full_strings();
    test_backpressure();
    test_random();
    if (!failed)
      $display("shortest_common_supersequence_unit_test passed");
    else
      $display("shortest_common_supersequence_unit_test failed");
    $finish;
  end
endmodule
